@@ sv/sli_pkg.sv @@
// Shared types and constants for the sorted list insert block.
// Holds the item and result words, the op codes and the cell link type.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int VALUE_W  = 32;
    localparam int RIDX_W   = 4;
    localparam int ECNT_W   = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [VALUE_W-1:0]  value;
        logic        [RIDX_W-1:0]   read_index;
    } t_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  read_value;
        logic        [ECNT_W-1:0]   entry_count;
        logic                       dropped;
        logic                       index_valid;
    } t_result;

    typedef struct packed {
        logic                       ge;
        logic signed [VALUE_W-1:0]  value;
    } t_link;

endpackage

@@ sv/sli_cell.sv @@
// One cell of the sorted list: holds one entry and shifts it up on insert.
// Depends on sli_pkg for the link type and value width.
module sli_cell (
    input  logic                               i_clk,
    input  logic                               i_insert,
    input  logic                               i_occupied,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_new,
    input  sli_pkg::t_link                     i_left,
    output sli_pkg::t_link                     o_link
);

    logic signed [sli_pkg::VALUE_W-1:0] r_value;
    logic signed [sli_pkg::VALUE_W-1:0] n_value;
    logic                               ge;

    always_comb begin
        ge = !i_occupied || (i_new < r_value);
        if (ge) begin
            n_value = i_left.ge ? i_left.value : i_new;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_insert) begin
            r_value <= n_value;
        end
    end

    assign o_link.ge    = ge;
    assign o_link.value = r_value;

endmodule

@@ sv/sorted_list_insert.sv @@
// Sorted list insert top level: a row of sli_cell entries plus count and result.
// The result strobe rises in the cycle after start is accepted.
// Throughput: one item per cycle; busy stays low, every cell compares in parallel.
// Reset: synchronous active low; clears the entry count and result strobe only.
// Entry contents are not cleared; only entries below the count are ever read.
// Depends on sli_pkg and sli_cell.
module sorted_list_insert (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sli_pkg::t_item     i_item,
    output logic               o_valid,
    output sli_pkg::t_result   o_result
);

    logic [sli_pkg::CNT_W-1:0] r_count;
    logic [sli_pkg::CNT_W-1:0] n_count;
    logic                      r_valid;
    sli_pkg::t_result          r_result;
    sli_pkg::t_result          n_result;

    logic                      accept;
    logic                      full;
    logic                      insert;
    logic [sli_pkg::IDX_W-1:0] rd_addr;
    logic                      rd_ok;

    sli_pkg::t_link            links [sli_pkg::CAPACITY];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (r_count == sli_pkg::CNT_W'(sli_pkg::CAPACITY));
    assign insert = accept && (i_item.op == sli_pkg::OP_INSERT) && !full;

    genvar g;
    generate
        for (g = 0; g < sli_pkg::CAPACITY; g++) begin : g_cell
            sli_pkg::t_link left;
            if (g == 0) begin : g_first
                assign left = '0;
            end else begin : g_rest
                assign left = links[g-1];
            end
            sli_cell u_cell (
                .i_clk      (i_clk),
                .i_insert   (insert),
                .i_occupied (sli_pkg::CNT_W'(g) < r_count),
                .i_new      (i_item.value),
                .i_left     (left),
                .o_link     (links[g])
            );
        end
    endgenerate

    always_comb begin
        rd_addr  = sli_pkg::IDX_W'(i_item.read_index);
        rd_ok    = (sli_pkg::CNT_W'(i_item.read_index) < r_count);
        n_count  = insert ? r_count + 1'b1 : r_count;
        n_result = '0;
        n_result.entry_count = sli_pkg::ECNT_W'(n_count);
        case (i_item.op)
            sli_pkg::OP_INSERT: begin
                n_result.dropped = full;
            end
            sli_pkg::OP_READ: begin
                n_result.index_valid = rd_ok;
                n_result.read_value  = rd_ok ? links[rd_addr].value : '0;
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sli_pkg::CNT_W'(sli_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        insert |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not advance the count");

    a_strobe_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted word gave no result strobe");

    a_drop_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.dropped) |->
            (r_count == sli_pkg::CNT_W'(sli_pkg::CAPACITY)))
        else $error("drop flagged on a list that is not full");

    a_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= sli_pkg::CNT_W'(2)) |-> (links[0].value <= links[1].value))
        else $error("lowest entries out of order");

endmodule
